[src/bcgs_pkg.sv]
`default_nettype none
package bcgs_pkg;

  localparam int FreqW  = 17;
  localparam int StepW  = 8;
  localparam int BandW  = 3;
  localparam int RecipW = 25;

  localparam logic [BandW-1:0] BandLw   = 3'd0;
  localparam logic [BandW-1:0] BandMw   = 3'd1;
  localparam logic [BandW-1:0] BandSw   = 3'd2;
  localparam logic [BandW-1:0] BandOirt = 3'd3;
  localparam logic [BandW-1:0] BandFm   = 3'd4;

  localparam logic CfgFmRegion  = 1'b0;
  localparam logic CfgMwSpacing = 1'b1;

  typedef struct packed {
    logic             kind;
    logic [BandW-1:0] band;
    logic [FreqW-1:0] freq;
    logic [StepW-1:0] step;
    logic [FreqW-1:0] lo;
    logic [FreqW-1:0] hi;
    logic             ok;
    logic             in_band;
    logic [BandW-1:0] home;
    logic             found;
  } job_t;

  typedef struct packed {
    logic [FreqW-1:0] lo;
    logic [FreqW-1:0] hi;
  } edges_t;

  function automatic edges_t band_edges(logic [BandW-1:0] b, logic [2:0] reg_fm,
                                        logic mw);
    edges_t e;
    e.lo = '0;
    e.hi = '0;
    unique case (b)
      BandLw: begin e.lo = 17'd144; e.hi = 17'd513; end
      BandMw: begin
        e.lo = mw ? 17'd520 : 17'd522;
        e.hi = mw ? 17'd1720 : 17'd1791;
      end
      BandSw: begin e.lo = 17'd1700; e.hi = 17'd27000; end
      BandOirt: begin e.lo = 17'd65000; e.hi = 17'd74000; end
      BandFm: begin
        e.hi = 17'd108000;
        unique case (reg_fm)
          3'd1: begin e.lo = 17'd76000; e.hi = 17'd95000; end
          3'd2: e.lo = 17'd76000;
          3'd3: e.lo = 17'd87000;
          3'd4: e.lo = 17'd87500;
          default: e.lo = 17'd65000;
        endcase
      end
      default: ;
    endcase
    return e;
  endfunction

  // ceil(2^24 / step): exact floor quotient for any 16-bit dividend
  function automatic logic [RecipW-1:0] step_recip(logic [StepW-1:0] s);
    logic [RecipW-1:0] m;
    unique case (s)
      8'd1:    m = 25'd16777216;
      8'd5:    m = 25'd3355444;
      8'd9:    m = 25'd1864136;
      8'd10:   m = 25'd1677722;
      8'd30:   m = 25'd559241;
      8'd50:   m = 25'd335545;
      8'd100:  m = 25'd167773;
      8'd200:  m = 25'd83887;
      default: m = '0;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

[src/bcgs_front.sv]
`default_nettype none
module bcgs_front (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire logic                      in_kind,
  input  wire logic [bcgs_pkg::BandW-1:0] in_band,
  input  wire logic [bcgs_pkg::FreqW-1:0] in_frequency,
  input  wire logic [bcgs_pkg::StepW-1:0] in_step_size,
  input  wire logic [2:0]                fm_region,
  input  wire logic                      mw_spacing,
  output logic                           q_valid,
  output bcgs_pkg::job_t                 q_job,
  input  wire logic                      q_pop
);
  // two-entry queue to the back end
  bcgs_pkg::job_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  bcgs_pkg::job_t j;
  bcgs_pkg::edges_t e;
  logic push;

  always_comb begin
    e = bcgs_pkg::band_edges(in_band, fm_region, mw_spacing);
    j.kind = in_kind;
    j.band = in_band;
    j.freq = in_frequency;
    j.step = in_step_size;
    j.lo = e.lo;
    j.hi = e.hi;
    unique case (in_band)
      bcgs_pkg::BandLw:   j.ok = in_step_size == 8'd1 || in_step_size == 8'd9;
      bcgs_pkg::BandMw:   j.ok = in_step_size == 8'd1 ||
                                 in_step_size == (mw_spacing ? 8'd10 : 8'd9);
      bcgs_pkg::BandSw:   j.ok = in_step_size == 8'd1 || in_step_size == 8'd5;
      bcgs_pkg::BandOirt: j.ok = in_step_size == 8'd10 || in_step_size == 8'd30;
      bcgs_pkg::BandFm:   j.ok = in_step_size == 8'd50 || in_step_size == 8'd100 ||
                                 in_step_size == 8'd200;
      default:            j.ok = 1'b0;
    endcase
    j.in_band = (in_band <= bcgs_pkg::BandFm) && in_frequency >= e.lo &&
                in_frequency <= e.hi;
    j.home = '0;
    j.found = 1'b0;
    for (int b = 4; b >= 0; b--) begin
      bcgs_pkg::edges_t eb;
      eb = bcgs_pkg::band_edges(b[bcgs_pkg::BandW-1:0], fm_region, mw_spacing);
      if (in_frequency >= eb.lo && in_frequency <= eb.hi) begin
        j.home = b[bcgs_pkg::BandW-1:0];
        j.found = 1'b1;
      end
    end
  end

  assign in_stall = cnt_r == 2'd2;
  assign push = in_valid && !in_stall;
  assign q_valid = cnt_r != 2'd0;
  assign q_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= j;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (q_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue count overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_full: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && !q_pop) |=> in_stall)
    else $error("full queue not stalling");
endmodule
`default_nettype wire

[src/bcgs_back.sv]
`default_nettype none
module bcgs_back (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       q_valid,
  input  bcgs_pkg::job_t                  q_job,
  output logic                            q_pop,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bcgs_pkg::FreqW-1:0]      out_new_frequency,
  output logic                            out_step_ok,
  output logic                            out_in_band,
  output logic [bcgs_pkg::BandW-1:0]      out_home_band,
  output logic                            out_home_found
);
  // three phases: reciprocal multiply, grid multiply, select
  bcgs_pkg::job_t job_r;
  logic busy_r;
  logic [1:0] ph_r;
  logic [15:0] off_r, span_r;               // f-lo and hi-lo
  logic [bcgs_pkg::RecipW-1:0] recip_r;
  logic [15:0] qa_r, qb_r;                  // quotients of f-lo and hi-lo
  logic [23:0] pa_r, pb_r;                  // quotients times step
  logic [40:0] prod_a, prod_b;
  logic done, take, rem_zero;
  logic [24:0] lo_x, nx, top, base, below;
  logic [bcgs_pkg::FreqW-1:0] nf;

  assign done = busy_r && ph_r == 2'd2;
  assign take = done && (!out_valid || !out_stall);
  assign q_pop = q_valid && !busy_r;
  assign prod_a = 41'(off_r) * 41'(recip_r);
  assign prod_b = 41'(span_r) * 41'(recip_r);

  always_comb begin
    lo_x = 25'(job_r.lo);
    nx = lo_x + 25'(pa_r) + 25'(job_r.step);
    top = lo_x + 25'(pb_r);
    base = lo_x + 25'(pa_r);
    below = base - 25'(job_r.step);
    rem_zero = pa_r == 24'(off_r);
    nf = job_r.freq;
    if (job_r.ok) begin
      if (!job_r.kind) begin
        if (job_r.freq < job_r.lo || job_r.freq >= job_r.hi) nf = job_r.lo;
        else nf = (nx > 25'(job_r.hi)) ? job_r.lo : nx[bcgs_pkg::FreqW-1:0];
      end else begin
        if (job_r.freq <= job_r.lo || job_r.freq > job_r.hi) nf = top[bcgs_pkg::FreqW-1:0];
        else if (!rem_zero) nf = base[bcgs_pkg::FreqW-1:0];
        else if (qa_r == '0) nf = top[bcgs_pkg::FreqW-1:0];
        else nf = below[bcgs_pkg::FreqW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      off_r <= 16'(q_job.freq - q_job.lo);
      span_r <= 16'(q_job.hi - q_job.lo);
      recip_r <= bcgs_pkg::step_recip(q_job.step);
    end
    qa_r <= 16'(prod_a >> 24);
    qb_r <= 16'(prod_b >> 24);
    pa_r <= 24'(qa_r) * 24'(job_r.step);
    pb_r <= 24'(qb_r) * 24'(job_r.step);
    if (take) begin
      out_new_frequency <= nf;
      out_step_ok <= job_r.ok;
      out_in_band <= job_r.in_band;
      out_home_band <= job_r.home;
      out_home_found <= job_r.found;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r <= 2'd0;
      out_valid <= 1'b0;
    end else begin
      if (q_pop) begin
        busy_r <= 1'b1;
        ph_r <= 2'd0;
      end else if (busy_r && !done) begin
        ph_r <= ph_r + 2'd1;
      end else if (take) begin
        busy_r <= 1'b0;
      end
      if (take) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid)
    else $error("result dropped under stall");
  a_keep: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(out_new_frequency))
    else $error("result changed under stall");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |=> busy_r && ph_r == 2'd0)
    else $error("job not started");
  a_ph: assert property (@(posedge clk) disable iff (!rst_n)
    ph_r <= 2'd2)
    else $error("phase count overrun");
endmodule
`default_nettype wire

[src/band_channel_grid_stepper_top.sv]
`default_nettype none
// channel | handshake      | payload
// in      | valid / stall  | kind, band, frequency, step_size
// out     | valid / stall  | new_frequency, step_ok, in_band, home_band, home_found
// cfg     | valid / ready  | index, data (0 fm_region, 1 mw_spacing)
// An accepted item leaves the queue, then passes reciprocal multiply, grid
// multiply and select in the back end. The back end takes a new item only
// once its last result is taken; a two-entry queue lets the front accept back
// to back while the back end works or its result stalls, until it is full.
// Synchronous active-low reset empties queue and output; fm_region resets
// to 4, mw_spacing to 0.
module band_channel_grid_stepper_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic                       in_kind,
  input  wire logic [bcgs_pkg::BandW-1:0] in_band,
  input  wire logic [bcgs_pkg::FreqW-1:0] in_frequency,
  input  wire logic [bcgs_pkg::StepW-1:0] in_step_size,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic [bcgs_pkg::FreqW-1:0]      out_new_frequency,
  output logic                            out_step_ok,
  output logic                            out_in_band,
  output logic [bcgs_pkg::BandW-1:0]      out_home_band,
  output logic                            out_home_found,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [2:0]                 cfg_data
);
  logic [2:0] fm_region_r;
  logic mw_spacing_r;
  logic q_valid, q_pop;
  bcgs_pkg::job_t q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fm_region_r <= 3'd4;
      mw_spacing_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        bcgs_pkg::CfgFmRegion:  fm_region_r <= cfg_data;
        bcgs_pkg::CfgMwSpacing: mw_spacing_r <= cfg_data[0];
      endcase
    end
  end

  bcgs_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_kind, .in_band, .in_frequency,
    .in_step_size, .fm_region(fm_region_r), .mw_spacing(mw_spacing_r),
    .q_valid, .q_job, .q_pop
  );

  bcgs_back u_back (
    .clk, .rst_n, .q_valid, .q_job, .q_pop, .out_valid, .out_stall,
    .out_new_frequency, .out_step_ok, .out_in_band, .out_home_band,
    .out_home_found
  );
endmodule
`default_nettype wire

[tb/tb_tuning_checker.sv]
`default_nettype none
module tb_tuning_checker (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  input  wire logic                       in_stall,
  input  wire logic                       in_kind,
  input  wire logic [bcgs_pkg::BandW-1:0] in_band,
  input  wire logic [bcgs_pkg::FreqW-1:0] in_frequency,
  input  wire logic [bcgs_pkg::StepW-1:0] in_step_size,
  input  wire logic                       out_valid,
  input  wire logic                       out_stall,
  input  wire logic [bcgs_pkg::FreqW-1:0] out_new_frequency,
  input  wire logic                       out_step_ok,
  input  wire logic                       out_in_band,
  input  wire logic [bcgs_pkg::BandW-1:0] out_home_band,
  input  wire logic                       out_home_found,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic                       cfg_index,
  input  wire logic [2:0]                 cfg_data,
  output int                              fail_count,
  output int                              pending,
  output int                              tuned_count
);
  typedef logic [bcgs_pkg::FreqW-1:0] freq_t;
  typedef logic [bcgs_pkg::BandW-1:0] band_t;

  typedef struct packed {
    freq_t freq;
    logic  ok;
    logic  in_band;
    band_t home;
    logic  found;
  } tune_t;

  tune_t     tune_q[$];
  logic [2:0] fm_plan;
  logic       mw_10k;

  function automatic logic band_span(input band_t b, input logic [2:0] plan,
                                     input logic mw, output int lo, output int hi);
    lo = 0;
    hi = 0;
    case (b)
      bcgs_pkg::BandLw: begin lo = 144; hi = 513; end
      bcgs_pkg::BandMw: begin lo = mw ? 520 : 522; hi = mw ? 1720 : 1791; end
      bcgs_pkg::BandSw: begin lo = 1700; hi = 27000; end
      bcgs_pkg::BandOirt: begin lo = 65000; hi = 74000; end
      bcgs_pkg::BandFm: begin
        case (plan)
          3'd1: begin lo = 76000; hi = 95000; end
          3'd2: begin lo = 76000; hi = 108000; end
          3'd3: begin lo = 87000; hi = 108000; end
          3'd4: begin lo = 87500; hi = 108000; end
          default: begin lo = 65000; hi = 108000; end
        endcase
      end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic tune_t predict_tune(input logic dn, input band_t b,
                                         input freq_t fq,
                                         input logic [bcgs_pkg::StepW-1:0] st);
    tune_t r;
    int f, s, lo, hi, top, off, k;
    logic known, allowed;
    f = int'(fq);
    s = int'(st);
    r = '0;
    r.freq = fq;
    known = band_span(b, fm_plan, mw_10k, lo, hi);
    case (b)
      bcgs_pkg::BandLw: allowed = s == 1 || s == 9;
      bcgs_pkg::BandMw: allowed = s == 1 || s == (mw_10k ? 10 : 9);
      bcgs_pkg::BandSw: allowed = s == 1 || s == 5;
      bcgs_pkg::BandOirt: allowed = s == 10 || s == 30;
      bcgs_pkg::BandFm: allowed = s == 50 || s == 100 || s == 200;
      default: allowed = 1'b0;
    endcase
    if (known && allowed) begin
      r.ok = 1'b1;
      if (!dn) begin
        if (f < lo || f >= hi) r.freq = freq_t'(lo);
        else begin
          k = lo + ((f - lo) / s + 1) * s;
          r.freq = k > hi ? freq_t'(lo) : freq_t'(k);
        end
      end else begin
        top = lo + ((hi - lo) / s) * s;
        if (f <= lo || f > hi) r.freq = freq_t'(top);
        else begin
          off = f - lo;
          k = off / s;
          if (off % s != 0) r.freq = freq_t'(lo + k * s);
          else r.freq = (k == 0) ? freq_t'(top) : freq_t'(lo + (k - 1) * s);
        end
      end
    end
    r.in_band = known && f >= lo && f <= hi;
    for (int i = 0; i < 5; i++) begin
      if (band_span(band_t'(i), fm_plan, mw_10k, lo, hi) && f >= lo && f <= hi) begin
        r.home = band_t'(i);
        r.found = 1'b1;
        break;
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    tune_t exp_t;
    if (!rst_n) begin
      fm_plan <= 3'd4;
      mw_10k <= 1'b0;
      fail_count <= 0;
      tuned_count <= 0;
      tune_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == bcgs_pkg::CfgFmRegion) fm_plan <= cfg_data;
        else mw_10k <= cfg_data[0];
      end
      if (in_valid && !in_stall)
        tune_q.push_back(predict_tune(in_kind, in_band, in_frequency, in_step_size));
      if (out_valid && !out_stall) begin
        tuned_count <= tuned_count + 1;
        if (tune_q.size() == 0) begin
          $error("unexpected item: new_frequency %0d", out_new_frequency);
          fail_count <= fail_count + 1;
        end else begin
          exp_t = tune_q.pop_front();
          if (out_new_frequency !== exp_t.freq || out_step_ok !== exp_t.ok ||
              out_in_band !== exp_t.in_band || out_home_band !== exp_t.home ||
              out_home_found !== exp_t.found) begin
            fail_count <= fail_count + 1;
            if (out_new_frequency !== exp_t.freq)
              $error("new_frequency: expected %0d got %0d", exp_t.freq, out_new_frequency);
            if (out_step_ok !== exp_t.ok)
              $error("step_ok: expected %0d got %0d", exp_t.ok, out_step_ok);
            if (out_in_band !== exp_t.in_band)
              $error("in_band: expected %0d got %0d", exp_t.in_band, out_in_band);
            if (out_home_band !== exp_t.home)
              $error("home_band: expected %0d got %0d", exp_t.home, out_home_band);
            if (out_home_found !== exp_t.found)
              $error("home_found: expected %0d got %0d", exp_t.found, out_home_found);
          end
        end
      end
    end
  end

  assign pending = tune_q.size();
endmodule
`default_nettype wire

[tb/tb_top.sv]
`default_nettype none
module tb_top;
  typedef logic [bcgs_pkg::FreqW-1:0] freq_t;
  typedef logic [bcgs_pkg::BandW-1:0] band_t;
  typedef logic [bcgs_pkg::StepW-1:0] step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0, in_kind = 1'b0, out_stall = 1'b0;
  band_t in_band = '0;
  freq_t in_frequency = '0;
  step_t in_step_size = '0;
  logic cfg_valid = 1'b0, cfg_index = 1'b0;
  logic [2:0] cfg_data = '0;
  logic in_stall, out_valid, out_step_ok, out_in_band, out_home_found, cfg_ready;
  freq_t out_new_frequency;
  band_t out_home_band;
  int fail_count, pending, tuned_count;
  bit calm = 1'b0;
  int sent = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  band_channel_grid_stepper_top DUT (.*);
  tb_tuning_checker u_checker (.*);

  // receiver backpressure, off during the calm stretch
  always @(posedge clk) out_stall <= !calm && ($urandom_range(99) < 22);

  task automatic send_tune(input logic k, input band_t b, input freq_t f,
                           input step_t s);
    while (!calm && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= k;
    in_band <= b;
    in_frequency <= f;
    in_step_size <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain_and_settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [2:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic step_t pick_step(input band_t b);
    case ($urandom_range(9))
      0: return step_t'($urandom);
      1: return 8'd1;
      2: return 8'd9;
      3: return 8'd10;
      4: return 8'd5;
      5: return 8'd30;
      6: return 8'd50;
      7: return 8'd100;
      8: return 8'd200;
      default: return b == bcgs_pkg::BandFm ? 8'd100 :
                      (b == bcgs_pkg::BandOirt ? 8'd10 : 8'd1);
    endcase
  endfunction

  function automatic freq_t pick_freq();
    case ($urandom_range(9))
      0: return freq_t'($urandom);
      1: return freq_t'($urandom_range(600));
      2: return freq_t'($urandom_range(1900, 400));
      3: return freq_t'($urandom_range(27100, 1600));
      4: return freq_t'($urandom_range(75000, 64000));
      5, 6: return freq_t'($urandom_range(109000, 64000));
      7: begin
        // exact grid points and edges
        case ($urandom_range(5))
          0: return freq_t'(144 + 9 * $urandom_range(41));
          1: return freq_t'(522 + 9 * $urandom_range(141));
          2: return freq_t'(520 + 10 * $urandom_range(120));
          3: return freq_t'(1700 + 5 * $urandom_range(5060));
          4: return freq_t'(65000 + 30 * $urandom_range(300));
          default: return freq_t'(87500 + 100 * $urandom_range(205));
        endcase
      end
      default: return freq_t'(87000 + 50 * $urandom_range(440));
    endcase
  endfunction

  task automatic random_burst(input int n);
    band_t b;
    repeat (n) begin
      b = ($urandom_range(19) == 0) ? band_t'($urandom_range(7, 5)) :
                                      band_t'($urandom_range(4));
      send_tune(1'($urandom_range(1)), b, pick_freq(), pick_step(b));
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: reset settings, edges, wraps, bad steps, unknown bands
    send_tune(1'b0, bcgs_pkg::BandLw, 17'd144, 8'd9);
    send_tune(1'b0, bcgs_pkg::BandLw, 17'd513, 8'd9);
    send_tune(1'b1, bcgs_pkg::BandLw, 17'd144, 8'd9);
    send_tune(1'b1, bcgs_pkg::BandLw, 17'd150, 8'd9);
    send_tune(1'b1, bcgs_pkg::BandLw, 17'd153, 8'd9);
    send_tune(1'b0, bcgs_pkg::BandLw, 17'd510, 8'd1);
    send_tune(1'b0, bcgs_pkg::BandMw, 17'd1785, 8'd9);
    send_tune(1'b1, bcgs_pkg::BandMw, 17'd100, 8'd9);
    send_tune(1'b0, bcgs_pkg::BandMw, 17'd600, 8'd10);
    send_tune(1'b0, bcgs_pkg::BandSw, 17'd26999, 8'd5);
    send_tune(1'b1, bcgs_pkg::BandSw, 17'd27001, 8'd1);
    send_tune(1'b0, bcgs_pkg::BandOirt, 17'd73990, 8'd30);
    send_tune(1'b1, bcgs_pkg::BandOirt, 17'd65000, 8'd30);
    send_tune(1'b0, bcgs_pkg::BandFm, 17'd107950, 8'd50);
    send_tune(1'b1, bcgs_pkg::BandFm, 17'd87500, 8'd200);
    send_tune(1'b0, bcgs_pkg::BandFm, 17'd90000, 8'd0);
    send_tune(1'b0, 3'd7, 17'd100000, 8'd100);
    send_tune(1'b1, 3'd5, 17'd0, 8'd1);
    send_tune(1'b1, bcgs_pkg::BandFm, '1, 8'hFF);
    send_tune(1'b0, bcgs_pkg::BandSw, 17'd140, 8'd5);
    send_tune(1'b1, bcgs_pkg::BandMw, 17'd1791, 8'd1);
    drain_and_settle();

    // walk every register setting, extremes included
    for (int plan = 0; plan < 8; plan++) begin
      write_reg(bcgs_pkg::CfgFmRegion, plan[2:0]);
      write_reg(bcgs_pkg::CfgMwSpacing, {2'b00, plan[0]});
      if (plan == 3) calm = 1'b1;
      random_burst(plan < 5 ? 60 : 20);
      calm = 1'b0;
      drain_and_settle();
    end
    write_reg(bcgs_pkg::CfgFmRegion, 3'd4);
    write_reg(bcgs_pkg::CfgMwSpacing, 3'd0);
    random_burst(60);
    drain_and_settle();

    $display("Sent %0d tuning items over all FM plans and both MW spacings;", sent);
    $display("%0d results checked.", tuned_count);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin
    #2000000;
    $display("TEST FAILED");
    $finish;
  end
endmodule
`default_nettype wire

[band_channel_grid_stepper_top.f]
src/bcgs_pkg.sv
src/bcgs_front.sv
src/bcgs_back.sv
src/band_channel_grid_stepper_top.sv
tb/tb_tuning_checker.sv
tb/tb_top.sv
